FILE: src/a85d_pkg.sv
// Shared types and constants for the Ascii85 stream decoder.
package a85d_pkg;

  // Width of the open-group value: four digits stay below 85**4.
  localparam int unsigned ACC_W       = 26;
  // Width of a digit value and of a completed group value.
  localparam int unsigned DIGIT_W     = 7;
  localparam int unsigned GROUP_W     = 33;
  localparam int unsigned PAD_W       = 20;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_BANG  = 8'h21;
  localparam logic [7:0] CHAR_U     = 8'h75;
  localparam logic [7:0] CHAR_Z     = 8'h7a;

  localparam logic [GROUP_W-1:0] RADIX = GROUP_W'(85);

  localparam logic       CMD_DATA  = 1'b0;
  localparam logic       CMD_FLUSH = 1'b1;

  localparam logic [1:0] STATUS_DATA  = 2'd0;
  localparam logic [1:0] STATUS_ERROR = 2'd1;
  localparam logic [1:0] STATUS_END   = 2'd2;

  typedef enum logic [1:0] {
    JOB_DATA,
    JOB_ERROR,
    JOB_END
  } job_kind_e;

  // One queued job: a data word with the index of its last byte, or a
  // single error or end result.
  typedef struct packed {
    job_kind_e   kind;
    logic [31:0] word;
    logic [1:0]  last_idx;
  } job_t;

  // Multiplier for padding an open group of nb digits with digit 84:
  // (v + 1) * 85**(5 - nb) - 1.
  function automatic logic [PAD_W-1:0] pad_factor(input logic [2:0] nb);
    logic [PAD_W-1:0] f;
    f = PAD_W'(85);
    unique case (nb)
      3'd2:    f = PAD_W'(614125);
      3'd3:    f = PAD_W'(7225);
      default: f = PAD_W'(85);
    endcase
    return f;
  endfunction

endpackage

FILE: src/a85d_front.sv
// Front end: accept characters, track the open group and queue result jobs.
module a85d_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          cmd_i,
  input  logic [7:0]    char_in_i,
  input  logic          q_full_i,
  output logic          push_o,
  output a85d_pkg::job_t job_o
);
  import a85d_pkg::*;

  logic [ACC_W-1:0]         acc_q, acc_d;
  logic [2:0]               nb_q, nb_d;
  logic                     err_q, err_d;
  logic                     accept;
  logic [DIGIT_W-1:0]       digit;
  logic [GROUP_W-1:0]       grown;
  logic [ACC_W+PAD_W-1:0]   padded_prod;
  logic [GROUP_W-1:0]       padded;
  logic                     is_digit;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign digit    = DIGIT_W'(char_in_i - CHAR_BANG);
  assign is_digit = (char_in_i >= CHAR_BANG) && (char_in_i <= CHAR_U);
  assign grown    = GROUP_W'(acc_q) * RADIX + GROUP_W'(digit);
  assign padded_prod = (ACC_W+PAD_W)'(acc_q + ACC_W'(1)) *
                       (ACC_W+PAD_W)'(pad_factor(nb_q));
  assign padded   = padded_prod[GROUP_W-1:0] - GROUP_W'(1);

  always_comb begin
    acc_d         = acc_q;
    nb_d          = nb_q;
    err_d         = err_q;
    push_o        = 1'b0;
    job_o.kind    = JOB_DATA;
    job_o.word    = '0;
    job_o.last_idx = 2'd3;
    if (accept) begin
      if (cmd_i == CMD_FLUSH) begin
        acc_d  = '0;
        nb_d   = '0;
        err_d  = 1'b0;
        push_o = 1'b1;
        if (err_q || nb_q == 3'd0) begin
          job_o.kind = JOB_END;
        end else if (nb_q == 3'd1 || padded[GROUP_W-1]) begin
          job_o.kind = JOB_ERROR;
        end else begin
          job_o.word     = padded[31:0];
          job_o.last_idx = 2'(nb_q - 3'd2);
        end
      end else if (!err_q && char_in_i > CHAR_SPACE) begin
        if (char_in_i == CHAR_Z && nb_q == 3'd0) begin
          push_o = 1'b1;
        end else if (is_digit) begin
          if (nb_q < 3'd4) begin
            acc_d = grown[ACC_W-1:0];
            nb_d  = nb_q + 3'd1;
          end else begin
            acc_d  = '0;
            nb_d   = '0;
            push_o = 1'b1;
            if (grown[GROUP_W-1]) begin
              job_o.kind = JOB_ERROR;
              err_d      = 1'b1;
            end else begin
              job_o.word = grown[31:0];
            end
          end
        end else begin
          // Stray character: drop the open group and report once.
          acc_d      = '0;
          nb_d       = '0;
          err_d      = 1'b1;
          push_o     = 1'b1;
          job_o.kind = JOB_ERROR;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      nb_q  <= '0;
      err_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      nb_q  <= nb_d;
      err_q <= err_d;
    end
  end

endmodule

FILE: src/a85d_queue.sv
// Short job queue between the front and back ends.
module a85d_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  a85d_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output a85d_pkg::job_t head_o,
  output logic           empty_o
);
  import a85d_pkg::*;

  job_t                entries_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   count_q;

  assign full_o  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QUEUE_AW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

FILE: src/a85d_back.sv
// Back end: expand queued jobs into result requests behind an output register.
module a85d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  a85d_pkg::job_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     byte_out_o,
  output logic [1:0]     status_o,
  output logic           last_o
);
  import a85d_pkg::*;

  logic       out_valid_q;
  logic [7:0] byte_q, byte_d;
  logic [1:0] status_q, status_d;
  logic       last_q, last_d;
  logic [1:0] idx_q;
  logic       load;
  logic       emit;
  logic [7:0] sel_byte;

  assign load  = !out_valid_q || !out_stall_i;
  assign emit  = load && !empty_i;

  always_comb begin
    unique case (idx_q)
      2'd0:    sel_byte = head_i.word[31:24];
      2'd1:    sel_byte = head_i.word[23:16];
      2'd2:    sel_byte = head_i.word[15:8];
      default: sel_byte = head_i.word[7:0];
    endcase
  end

  always_comb begin
    byte_d   = 8'd0;
    status_d = STATUS_DATA;
    last_d   = 1'b1;
    unique case (head_i.kind)
      JOB_DATA: begin
        byte_d = sel_byte;
        last_d = (idx_q == head_i.last_idx);
      end
      JOB_ERROR: status_d = STATUS_ERROR;
      JOB_END:   status_d = STATUS_END;
      default:   status_d = STATUS_ERROR;
    endcase
  end

  assign pop_o = emit && last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      byte_q      <= '0;
      status_q    <= STATUS_DATA;
      last_q      <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= !empty_i;
      end
      if (emit) begin
        byte_q   <= byte_d;
        status_q <= status_d;
        last_q   <= last_d;
        idx_q    <= last_d ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign byte_out_o  = byte_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

`ifndef NO_ASSERTIONS
  a_single_non_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != STATUS_DATA |-> last_q)
    else $error("error or end result not marked last");

  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != STATUS_DATA |-> byte_q == 8'd0)
    else $error("non-data result carries a byte");

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i && head_i.kind == JOB_DATA |-> idx_q <= head_i.last_idx)
    else $error("byte index past end of job");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> idx_q == 2'd0)
    else $error("byte index held with no job queued");
`endif

endmodule

FILE: src/ascii85_stream_decoder.sv
// Top level of the Ascii85 stream decoder: front end, job queue and back end.
//
// Takes one Ascii85 character, or a flush, per request and returns decoded
// bytes most significant first. Characters at or below space are skipped;
// 'z' at a group start gives four zero bytes; a fifth digit completes a group
// and gives four bytes, or one format error if the group exceeds 32 bits.
// Any other character gives one format error, after which data is ignored
// until a flush. A flush finishes an open group (padded with digit 84) into
// one to three bytes, gives an error for a lone digit or a padded group
// over 32 bits, or a stream-end result otherwise, and returns the decoder to
// its reset state. Every result carries last on the final result caused by
// its input request. The front end takes one input request per cycle; the
// back end delivers one result per cycle unless the output stalls, so a
// request that yields four bytes holds the back end until all four are out.
// A two-entry job queue between them lets input continue while earlier
// bytes drain; the input stalls only when that queue is full.
module ascii85_stream_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic [1:0] status_o,
  output logic       last_o
);
  import a85d_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head_job;

  // Classify characters and build jobs.
  a85d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .char_in_i  (char_in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // Decouple the two sides.
  a85d_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (head_job),
    .empty_o    (q_empty)
  );

  // Expand jobs into result requests.
  a85d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .byte_out_o  (byte_out_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
